// File: src/hop_pkg.sv
// Package for the hexatic order parameter block.
// Holds the sequencer state type, datapath widths and the divider request struct.
// No dependencies.
package hop_pkg;

    localparam int REM_W = 35;   // divider partial remainder
    localparam int NUM_W = 38;   // divider numerator shifted in, MSB first
    localparam int QUO_W = 39;   // divider quotient
    localparam int DIV_W = 34;   // divisor
    localparam int MA_W  = 31;   // multiplier operand a
    localparam int MB_W  = 34;   // multiplier operand b
    localparam int PR_W  = MA_W + MB_W;

    localparam logic [5:0] FRAC_STEPS = 6'd31;
    localparam logic [5:0] MEAN_STEPS = 6'd39;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_COINCIDE  = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY  = 2'd2;

    localparam logic signed [37:0] Q_ONE     = 38'sd1073741824;
    localparam logic signed [37:0] INNER_LIM = 38'sd8589934592;

    localparam logic [2:0] ADDR_BOX_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_BOX_HEIGHT = 3'd4;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_DIFF  = 16'h0002,
        ST_FOLD  = 16'h0004,
        ST_NORM  = 16'h0008,
        ST_SQ    = 16'h0010,
        ST_DIVL  = 16'h0020,
        ST_DIVW  = 16'h0040,
        ST_MUL   = 16'h0080,
        ST_COMB  = 16'h0100,
        ST_CLAMP = 16'h0200,
        ST_IMUL  = 16'h0400,
        ST_ACC   = 16'h0800,
        ST_END   = 16'h1000,
        ST_MEANL = 16'h2000,
        ST_MEANW = 16'h4000,
        ST_OUT   = 16'h8000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  init_rem;
        logic [NUM_W-1:0]  numer;
        logic [DIV_W-1:0]  divisor;
        logic [5:0]        steps;
    } div_req_t;

    function automatic logic signed [37:0] clamp38(input logic signed [37:0] v,
                                                   input logic signed [37:0] lim);
        logic signed [37:0] r;
        r = v;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        return r;
    endfunction

endpackage

// File: src/hop_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Compare-then-shift step; numerator bits enter LSB side of the remainder.
// Depends on hop_pkg.
module hop_div
    import hop_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [REM_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic             ge;
    logic [REM_W-1:0] rem_sub;

    assign ge      = rem_reg >= REM_W'(dvs_reg);
    assign rem_sub = ge ? rem_reg - REM_W'(dvs_reg) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.init_rem;
            num_reg <= req.numer;
            dvs_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_sub[REM_W-2:0], num_reg[NUM_W-1]};
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: src/hexatic_order_parameter.sv
// Hexatic bond order parameter (psi6): top level, sequencer and shared multiplier.
// Depends on hop_pkg and hop_div.
//
// Each word carries a cell centre and one neighbour position (unsigned Q16.16). The
// bond is folded into the periodic box, reduced to 16-bit magnitudes, and its
// cos(6t)/sin(6t) are built from c^2, s^2 and c*s on one 31x34 multiplier and one
// bit-serial divider; in_ready is low while a word is worked on. A bond goes through up
// to 17 normalize shifts, three divisions and eleven multiplier products; a coincident
// or excess neighbour skips from the fold straight to the end state. The final word of
// a cell adds two divisions for the means; the result then sits in the output register
// until taken while the next word is already accepted.
module hexatic_order_parameter
    import hop_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         centre_x,
    input  logic [31:0]         centre_y,
    input  logic [31:0]         neighbour_x,
    input  logic [31:0]         neighbour_y,
    input  logic                final_neighbour,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_centre_x,
    output logic [31:0]         out_centre_y,
    output logic signed [31:0]  order_real,
    output logic signed [31:0]  order_imag,
    output logic [5:0]          bond_count,
    output logic [1:0]          status
);

    localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

    state_t state_reg, state_next;

    logic [31:0] box_w_reg, box_h_reg;
    logic [31:0] cx_reg, cy_reg, nx_reg, ny_reg;
    logic        last_reg;

    logic signed [32:0] dx_reg, dy_reg;
    logic [32:0] ax_reg, ay_reg;
    logic        xneg_reg, yneg_reg;
    logic [31:0] xx_reg, yy_reg, xy_reg;
    logic [32:0] r2_reg;
    logic [30:0] c2_reg, s2_reg, cs_reg;
    logic [30:0] c4_reg, s4_reg, c2s2_reg, pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [37:0] re_raw_reg, inner_raw_reg;
    logic signed [31:0] re_reg, im_reg;
    logic [33:0] inner_abs_reg;
    logic        im_neg_reg;
    logic [2:0]  idx_reg;

    logic signed [39:0] real_sum_reg, imag_sum_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]    status_reg;
    logic signed [31:0] mean_re_reg, mean_im_reg;

    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic [PR_W-1:0] prod_reg;
    logic [PR_W-1:0] prod_rnd;

    div_req_t          div_req;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_w_reg <= 32'd6553600;
            box_h_reg <= 32'd6553600;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                box_h_reg <= pwdata;
            else
                box_w_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_BOX_HEIGHT[2]) ? box_h_reg : box_w_reg;

    // ---------------- minimum image fold ----------------
    logic [31:0] magx, magy;
    logic        condx, condy;
    logic signed [33:0] rx, ry;
    logic        fnegx, fnegy;
    logic [32:0] fabsx, fabsy;

    always_comb
    begin
        magx  = dx_reg[32] ? 32'(-dx_reg) : dx_reg[31:0];
        magy  = dy_reg[32] ? 32'(-dy_reg) : dy_reg[31:0];
        condx = {magx, 1'b0} > {1'b0, box_w_reg};
        condy = {magy, 1'b0} > {1'b0, box_h_reg};
        rx    = $signed({2'b00, box_w_reg}) - $signed({2'b00, magx});
        ry    = $signed({2'b00, box_h_reg}) - $signed({2'b00, magy});
        if (condx)
        begin
            fnegx = (!dx_reg[32] && dx_reg != 33'sd0) ? (rx > 34'sd0) : rx[33];
            fabsx = rx[33] ? 33'(-rx) : rx[32:0];
        end
        else
        begin
            fnegx = dx_reg[32];
            fabsx = {1'b0, magx};
        end
        if (condy)
        begin
            fnegy = (!dy_reg[32] && dy_reg != 33'sd0) ? (ry > 34'sd0) : ry[33];
            fabsy = ry[33] ? 33'(-ry) : ry[32:0];
        end
        else
        begin
            fnegy = dy_reg[32];
            fabsy = {1'b0, magy};
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority if (state_reg == ST_SQ)
        begin
            unique case (idx_reg)
                3'd0:    begin mul_a = MA_W'(ax_reg[15:0]); mul_b = MB_W'(ax_reg[15:0]); end
                3'd1:    begin mul_a = MA_W'(ay_reg[15:0]); mul_b = MB_W'(ay_reg[15:0]); end
                default: begin mul_a = MA_W'(ax_reg[15:0]); mul_b = MB_W'(ay_reg[15:0]); end
            endcase
        end
        else if (state_reg == ST_MUL)
        begin
            unique case (idx_reg)
                3'd0:    begin mul_a = c2_reg; mul_b = MB_W'(c2_reg); end
                3'd1:    begin mul_a = s2_reg; mul_b = MB_W'(s2_reg); end
                3'd2:    begin mul_a = c2_reg; mul_b = MB_W'(s2_reg); end
                3'd3:    begin mul_a = c4_reg; mul_b = MB_W'(c2_reg); end
                3'd4:    begin mul_a = s4_reg; mul_b = MB_W'(s2_reg); end
                3'd5:    begin mul_a = c2_reg; mul_b = MB_W'(s4_reg); end
                default: begin mul_a = c4_reg; mul_b = MB_W'(s2_reg); end
            endcase
        end
        else
        begin
            mul_a = cs_reg;
            mul_b = inner_abs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PR_W'(mul_a) * PR_W'(mul_b);
    end

    // round half up, Q30
    assign prod_rnd = prod_reg + PR_W'(64'd1 << 29);

    // ---------------- divider ----------------
    logic [39:0] sum_abs;
    logic signed [39:0] mean_src;

    always_comb
    begin
        mean_src = (idx_reg == 3'd0) ? real_sum_reg : imag_sum_reg;
        sum_abs  = mean_src[39] ? 40'(-mean_src) : 40'(mean_src);
        div_req  = '0;
        if (state_reg == ST_DIVL)
        begin
            div_req.start   = 1'b1;
            div_req.divisor = DIV_W'(r2_reg);
            div_req.steps   = FRAC_STEPS;
            unique case (idx_reg)
                3'd0:    div_req.init_rem = REM_W'(xx_reg);
                3'd1:    div_req.init_rem = REM_W'(yy_reg);
                default: div_req.init_rem = REM_W'(xy_reg);
            endcase
        end
        else if (state_reg == ST_MEANL)
        begin
            div_req.start   = 1'b1;
            div_req.divisor = DIV_W'(count_reg);
            div_req.steps   = MEAN_STEPS;
            div_req.numer   = NUM_W'(sum_abs + 40'(count_reg >> 1));
        end
    end

    hop_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic [QUO_W-1:0] mean_q;
    logic signed [31:0] mean_val;

    always_comb
    begin
        mean_q   = (div_quo > QUO_W'(Q_ONE)) ? QUO_W'(Q_ONE) : div_quo;
        mean_val = mean_src[39] ? -$signed(32'(mean_q)) : $signed(32'(mean_q));
    end

    // ---------------- bond terms ----------------
    logic signed [37:0] sa, sb, sc, sd, s_c4, s_s4, s_cs;
    logic signed [37:0] re_comb, inner_comb, re_cl, inner_cl;
    logic [34:0] im_mag;
    logic [31:0] im_mag_cl;

    always_comb
    begin
        sa   = $signed({7'd0, pa_reg});
        sb   = $signed({7'd0, pb_reg});
        sc   = $signed({7'd0, pc_reg});
        sd   = $signed({7'd0, pd_reg});
        s_c4 = $signed({7'd0, c4_reg});
        s_s4 = $signed({7'd0, s4_reg});
        s_cs = $signed({7'd0, c2s2_reg});
        re_comb    = sa - sb + (((sc - sd) <<< 4) - (sc - sd));
        inner_comb = (s_c4 <<< 2) + (s_c4 <<< 1) - ((s_cs <<< 4) + (s_cs <<< 2))
                   + (s_s4 <<< 2) + (s_s4 <<< 1);
        re_cl      = clamp38(re_raw_reg, Q_ONE);
        inner_cl   = clamp38(inner_raw_reg, INNER_LIM);
        im_mag     = prod_rnd[PR_W-1:30];
        im_mag_cl  = (im_mag > 35'(Q_ONE)) ? 32'(Q_ONE) : im_mag[31:0];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_FOLD;
            ST_FOLD:
            begin
                if (count_reg >= CW'(MAX_NEIGHBOURS) || (fabsx == '0 && fabsy == '0))
                    state_next = ST_END;
                else
                    state_next = ST_NORM;
            end
            ST_NORM:  if (ax_reg[32:16] == '0 && ay_reg[32:16] == '0) state_next = ST_SQ;
            ST_SQ:    if (idx_reg == 3'd3) state_next = ST_DIVL;
            ST_DIVL:  state_next = ST_DIVW;
            ST_DIVW:  if (div_done) state_next = (idx_reg == 3'd2) ? ST_MUL : ST_DIVL;
            ST_MUL:   if (idx_reg == 3'd7) state_next = ST_COMB;
            ST_COMB:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_IMUL;
            ST_IMUL:  if (idx_reg == 3'd1) state_next = ST_ACC;
            ST_ACC:   state_next = ST_END;
            ST_END:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (count_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_MEANL;
            end
            ST_MEANL: state_next = ST_MEANW;
            ST_MEANW: if (div_done) state_next = (idx_reg == 3'd1) ? ST_OUT : ST_MEANL;
            ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 3'd0;
            real_sum_reg <= '0;
            imag_sum_reg <= '0;
            count_reg    <= '0;
            status_reg   <= STATUS_OK;
            out_valid    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                ST_FOLD:
                begin
                    if (count_reg >= CW'(MAX_NEIGHBOURS))
                        status_reg <= STATUS_TOO_MANY;
                    else if (fabsx == '0 && fabsy == '0 && status_reg == STATUS_OK)
                        status_reg <= STATUS_COINCIDE;
                end
                ST_NORM:
                begin
                    if (ax_reg[32:16] == '0 && ay_reg[32:16] == '0)
                        idx_reg <= 3'd0;
                end
                ST_SQ:    idx_reg <= (idx_reg == 3'd3) ? 3'd0 : idx_reg + 3'd1;
                ST_DIVW:
                begin
                    if (div_done)
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_MUL:   idx_reg <= (idx_reg == 3'd7) ? 3'd0 : idx_reg + 3'd1;
                ST_IMUL:  idx_reg <= (idx_reg == 3'd1) ? 3'd0 : idx_reg + 3'd1;
                ST_ACC:
                begin
                    real_sum_reg <= real_sum_reg + 40'(re_reg);
                    imag_sum_reg <= imag_sum_reg + 40'(im_reg);
                    count_reg    <= count_reg + CW'(1);
                end
                ST_END:   idx_reg <= 3'd0;
                ST_MEANW:
                begin
                    if (div_done)
                        idx_reg <= idx_reg + 3'd1;
                end
                ST_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        real_sum_reg <= '0;
                        imag_sum_reg <= '0;
                        count_reg    <= '0;
                        status_reg   <= STATUS_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cx_reg   <= centre_x;
                cy_reg   <= centre_y;
                nx_reg   <= neighbour_x;
                ny_reg   <= neighbour_y;
                last_reg <= final_neighbour;
            end
            ST_DIFF:
            begin
                dx_reg <= $signed({1'b0, nx_reg}) - $signed({1'b0, cx_reg});
                dy_reg <= $signed({1'b0, ny_reg}) - $signed({1'b0, cy_reg});
            end
            ST_FOLD:
            begin
                ax_reg   <= fabsx;
                ay_reg   <= fabsy;
                xneg_reg <= fnegx;
                yneg_reg <= fnegy;
            end
            ST_NORM:
            begin
                // shift both together until each fits 16 bits
                if (ax_reg[32:16] != '0 || ay_reg[32:16] != '0)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
            end
            ST_SQ:
            begin
                unique case (idx_reg)
                    3'd1:    xx_reg <= prod_reg[31:0];
                    3'd2:    yy_reg <= prod_reg[31:0];
                    3'd3:
                    begin
                        xy_reg <= prod_reg[31:0];
                        r2_reg <= 33'(xx_reg) + 33'(yy_reg);
                    end
                    default: ;
                endcase
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    unique case (idx_reg)
                        3'd0:    c2_reg <= div_quo[30:0];
                        3'd1:    s2_reg <= div_quo[30:0];
                        default: cs_reg <= div_quo[30:0];
                    endcase
                end
            end
            ST_MUL:
            begin
                unique case (idx_reg)
                    3'd1:    c4_reg   <= prod_rnd[60:30];
                    3'd2:    s4_reg   <= prod_rnd[60:30];
                    3'd3:    c2s2_reg <= prod_rnd[60:30];
                    3'd4:    pa_reg   <= prod_rnd[60:30];
                    3'd5:    pb_reg   <= prod_rnd[60:30];
                    3'd6:    pc_reg   <= prod_rnd[60:30];
                    3'd7:    pd_reg   <= prod_rnd[60:30];
                    default: ;
                endcase
            end
            ST_COMB:
            begin
                re_raw_reg    <= re_comb;
                inner_raw_reg <= inner_comb;
            end
            ST_CLAMP:
            begin
                re_reg        <= 32'(re_cl);
                inner_abs_reg <= inner_cl[37] ? 34'(-inner_cl) : 34'(inner_cl);
                im_neg_reg    <= (xneg_reg != yneg_reg) != inner_cl[37];
            end
            ST_IMUL:
            begin
                if (idx_reg == 3'd1)
                    im_reg <= im_neg_reg ? -$signed(im_mag_cl) : $signed(im_mag_cl);
            end
            ST_END:
            begin
                mean_re_reg <= '0;
                mean_im_reg <= '0;
            end
            ST_MEANW:
            begin
                if (div_done)
                begin
                    if (idx_reg == 3'd0)
                        mean_re_reg <= mean_val;
                    else
                        mean_im_reg <= mean_val;
                end
            end
            ST_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    out_centre_x <= cx_reg;
                    out_centre_y <= cy_reg;
                    order_real   <= mean_re_reg;
                    order_imag   <= mean_im_reg;
                    bond_count   <= 6'(count_reg);
                    status       <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// File: src/hop_checker.sv
// Port-level checks for the hexatic order parameter block.
// Bound to hexatic_order_parameter; depends on its ports only.
module hop_checker #(
    parameter int MAX_NEIGHBOURS = 32
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] order_real,
    input logic signed [31:0] order_imag,
    input logic [5:0]         bond_count,
    input logic [1:0]         status
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block ready right after taking a word");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> order_real <= 32'sd1073741824 && order_real >= -32'sd1073741824
                   && order_imag <= 32'sd1073741824 && order_imag >= -32'sd1073741824)
        else $error("mean outside unit range");

    a_empty_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (MAX_NEIGHBOURS < 64) && out_valid && bond_count == 6'd0
        |-> order_real == 32'sd0 && order_imag == 32'sd0)
        else $error("nonzero mean with no bonds");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(order_real) && $stable(order_imag))
        else $error("result word dropped or changed while stalled");

endmodule

bind hexatic_order_parameter hop_checker #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_hop_checker (.*);
